@@ src/f32as_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f32as_pkg
// shared constants for the truncating single-precision adder
// ----------------------------------------------------------------------------
package f32as_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam logic [ExpW-1:0] ExpSat = 8'd254;
  typedef enum logic {CMD_ADD = 1'b0, CMD_SUB = 1'b1} cmd_e;
endpackage
`default_nettype wire

@@ src/f32as_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// f32as channel interfaces
// valid/ready channels for operands and results
// ----------------------------------------------------------------------------
interface f32as_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] a_bits;
  logic [31:0] b_bits;
  modport source (output valid, cmd, a_bits, b_bits, input ready);
  modport sink   (input valid, cmd, a_bits, b_bits, output ready);
endinterface

interface f32as_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_bits;
  modport source (output valid, sum_bits, input ready);
  modport sink   (input valid, sum_bits, output ready);
endinterface
`default_nettype wire

@@ src/float32_add_sub_truncating_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float32_add_sub_truncating_core
// single-precision add/subtract, truncating alignment, flush-to-zero
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// in_ch   | in  | cmd, a_bits, b_bits
// out_ch  | out | sum_bits
//
// one beat per cycle while the output is not stalled; a result is registered in the result
// register after its operands pass the operand register; the two form a two-stage pipe
// stalls: each stage advances when empty or when the stage after it moves
// reset clears only the stage valid bits
module float32_add_sub_truncating_core
  import f32as_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  f32as_in_if.sink       in_ch,
  f32as_out_if.source    out_ch
);
  // operand stage
  logic        s1_vld_q;
  logic [31:0] a_q, b_q;
  logic        s1_go, s2_go;
  // result stage
  logic        s2_vld_q;
  logic [31:0] res_q, res_d;

  assign s2_go       = !s2_vld_q || out_ch.ready;
  assign s1_go       = !s1_vld_q || s2_go;
  assign in_ch.ready = s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_go) s1_vld_q <= in_ch.valid;
      if (s2_go) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && in_ch.valid) begin
      a_q <= in_ch.a_bits;
      // subtract folds into a flipped sign on b
      b_q <= {in_ch.b_bits[31] ^ (in_ch.cmd == CMD_SUB), in_ch.b_bits[30:0]};
    end
    if (s2_go && s1_vld_q) res_q <= res_d;
  end

  assign out_ch.valid    = s2_vld_q;
  assign out_ch.sum_bits = res_q;

  // datapath
  logic             xs, ys, ls, ss, a_big, a_zero, b_zero, take_lsb, carry;
  logic [ExpW-1:0]  xe, ye, le, se, e1, ef;
  logic [FracW-1:0] xf, yf;
  logic [23:0]      lm, sm, sm_sh, mn;
  logic [24:0]      m;
  logic [ExpW-1:0]  off;
  logic [4:0]       lz;
  logic [23:0]      mshift;

  always_comb begin
    xs = a_q[31]; xe = a_q[30:23]; xf = a_q[22:0];
    ys = b_q[31]; ye = b_q[30:23]; yf = b_q[22:0];
    a_zero = (xe == '0) && (xf == '0);
    b_zero = (ye == '0) && (yf == '0);
    a_big  = !((xe < ye) || ((xe == ye) && (xf < yf)));
    ls = a_big ? xs : ys;  ss = a_big ? ys : xs;
    le = a_big ? xe : ye;  se = a_big ? ye : xe;
    lm = {1'b1, a_big ? xf : yf};
    sm = {1'b1, a_big ? yf : xf};
    off = le - se;
    // shift of 24 or more empties a 24-bit significand; bit off-1 exists below 25
    sm_sh    = (off >= 8'd24) ? '0 : (sm >> off[4:0]);
    take_lsb = (off != '0) && (off <= 8'd24) && sm[off[4:0] - 5'd1];
    if (ls == ss) m = {1'b0, lm} + {1'b0, sm_sh};
    else          m = {1'b0, lm} - {1'b0, sm_sh} - {24'd0, take_lsb};
    carry = m[24];
    e1 = le;
    mn = m[23:0];
    if (carry) begin
      if (le >= ExpSat) begin
        e1 = 8'd255; mn = '0;
      end else begin
        e1 = le + 8'd1; mn = m[24:1];
      end
    end
    // leading-zero count for left normalize
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (mn[i]) lz = 5'(23 - i);
    end
    ef = e1;
    mshift = mn;
    if (mn != '0 && e1 != '0 && !mn[23]) begin
      if ({3'd0, lz} >= e1) begin
        ef = '0; mshift = '0;
      end else begin
        ef = e1 - {3'd0, lz}; mshift = mn << lz;
      end
    end
    if (a_zero)      res_d = b_zero ? '0 : b_q;
    else if (b_zero) res_d = a_q;
    else if (xf == yf && xe == ye && xs != ys) res_d = '0;
    else res_d = {ls, ef, mshift[22:0]};
  end

  // a result beat only follows a filled operand stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && !s1_vld_q) |=> !s2_vld_q) else $error("spurious result");
  // a held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !out_ch.ready) |=> $stable(res_q)) else $error("result lost");
  // an accepted beat reaches the operand stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> s1_vld_q) else $error("beat dropped");
endmodule
`default_nettype wire
